### rtl/dros_pkg.sv
package dros_pkg;

   // stream widths, tdata padded to whole bytes
   localparam int REQ_DATA_W = 184;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USER_W = 2;

   // operation selector
   localparam logic OP_INIT   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // record targets
   localparam logic TARGET_PRIMARY = 1'b0;
   localparam logic TARGET_BACKUP  = 1'b1;

   // recovery status codes
   localparam logic [1:0] STATUS_BOTH_VALID      = 2'd0;
   localparam logic [1:0] STATUS_BACKUP_REBUILT  = 2'd1;
   localparam logic [1:0] STATUS_PRIMARY_REBUILT = 2'd2;
   localparam logic [1:0] STATUS_BOTH_RESET      = 2'd3;

   // miles to feet in q16.16
   localparam int           FEET_W        = 32;
   localparam int           SCALED_W      = 45;
   localparam int           FRAC_W        = 16;
   localparam logic [12:0]  MILE_FEET     = 13'd5280;
   localparam logic [15:0]  ROUND_HALF    = 16'h8000;

   // crc-8, poly 0x07, init 0, msb first per byte
   localparam logic [7:0] CRC_POLY  = 8'h07;
   localparam int         CRC_MSG_W = 64;

   typedef struct packed {
      logic        write_enable;
      logic        write_target;
      logic [31:0] write_reading;
      logic [31:0] write_version;
      logic [7:0]  write_check;
      logic [1:0]  recovery_status;
      logic [31:0] odometer_feet;
      logic        final_result;
   } result_type;

   // bit-serial crc over the record bytes, reading first, little-endian
   function automatic logic [7:0] crc_serial(input logic [CRC_MSG_W-1:0] msg);
      logic [7:0] crc;
      crc = '0;
      for (int i = 0; i < CRC_MSG_W / 8; i++) begin
         crc = crc ^ msg[8*i +: 8];
         for (int k = 0; k < 8; k++) begin
            crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

   // contribution of each message bit, worked out at elaboration
   function automatic logic [CRC_MSG_W-1:0][7:0] crc_weight_table();
      logic [CRC_MSG_W-1:0][7:0] tbl;
      for (int j = 0; j < CRC_MSG_W; j++) begin
         tbl[j] = crc_serial(CRC_MSG_W'(1) << j);
      end
      return tbl;
   endfunction

   localparam logic [CRC_MSG_W-1:0][7:0] CRC_WEIGHT = crc_weight_table();

   // crc is linear with zero init: xor of per-bit weights, one flat tree
   function automatic logic [7:0] record_crc(input logic [31:0] reading,
                                             input logic [31:0] version);
      logic [CRC_MSG_W-1:0] msg;
      logic [7:0]           crc;
      msg = {version, reading};
      crc = '0;
      for (int j = 0; j < CRC_MSG_W; j++) begin
         if (msg[j]) begin
            crc = crc ^ CRC_WEIGHT[j];
         end
      end
      return crc;
   endfunction

endpackage

### rtl/dual_record_odometer_store.sv
// dual-copy odometer record store: keeps a primary and a backup record (feet, version,
// crc-8 over the 8 little-endian bytes) and emits the storage writes that keep them sound.
// an init word (tuser 0) checks the two records read from storage and repairs them: one
// result word, or two (primary then backup) when both records are bad. an update word
// (tuser 1) converts q16.16 miles to rounded feet, rolls primary into backup on a change
// and, on the first stop after motion with a change pending, writes backup then primary.
// each accepted word goes into an input register, is worked in combinational logic (one
// 32x13 multiply, a compare and a crc xor tree) and lands in a two-word result buffer.
// the buffer drains one word per cycle while rsp_tready is high; the next word moves on
// once it is empty or its last word is leaving. tlast marks the last result of a word.
module dual_record_odometer_store (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata from bit 0: stored_primary_reading, stored_primary_version,
   // stored_primary_check, stored_backup_reading, stored_backup_version,
   // stored_backup_check, moving, distance_miles, zero pad
   input  logic [dros_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser from bit 0: operation
   input  logic [dros_pkg::REQ_USER_W-1:0]    req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata from bit 0: write_reading, write_version, write_check,
   // recovery_status, odometer_feet, zero pad
   output logic [dros_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser from bit 0: write_enable, write_target
   output logic [dros_pkg::RSP_USER_W-1:0]    rsp_tuser,
   // last result word of the request word
   output logic                               rsp_tlast
);
   import dros_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        op_ff;
   logic [31:0] sp_reading_ff, sp_version_ff, sb_reading_ff, sb_version_ff;
   logic [7:0]  sp_check_ff, sb_check_ff;
   logic        moving_ff;
   logic [31:0] miles_ff;

   // record state
   logic [31:0] primary_reading_ff, primary_reading_in;
   logic [31:0] primary_version_ff, primary_version_in;
   logic [7:0]  primary_check_ff, primary_check_in;
   logic [31:0] backup_reading_ff, backup_reading_in;
   logic [31:0] backup_version_ff, backup_version_in;
   logic [7:0]  backup_check_ff, backup_check_in;
   logic        moved_since_save_ff, moved_since_save_in;
   logic        save_pending_ff, save_pending_in;

   // result buffer: head is on the port, tail waits behind it
   result_type  head_ff, head_in;
   result_type  tail_ff, tail_in;
   logic [1:0]  count_ff, count_in;

   logic        advance;
   logic        pop;
   logic        accept;

   // datapath for the word in the input register
   logic [SCALED_W-1:0] scaled;
   logic [FEET_W-1:0]   feet;
   logic [31:0]         bumped_version;
   logic                primary_ok, backup_ok;
   result_type          res0, res1;
   logic [1:0]          res_count;

   // handshakes
   assign pop        = (count_ff != 2'd0) && rsp_tready;
   assign advance    = in_valid_ff && ((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready));
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   // rounded feet: (miles * 5280 + half) >> 16
   assign scaled = SCALED_W'(miles_ff) * SCALED_W'(MILE_FEET) + SCALED_W'(ROUND_HALF);
   assign feet   = FEET_W'(scaled[SCALED_W-1:FRAC_W]);

   assign bumped_version = primary_version_ff + 32'd1;
   assign primary_ok     = record_crc(sp_reading_ff, sp_version_ff) == sp_check_ff;
   assign backup_ok      = record_crc(sb_reading_ff, sb_version_ff) == sb_check_ff;

   always_comb begin
      primary_reading_in  = primary_reading_ff;
      primary_version_in  = primary_version_ff;
      primary_check_in    = primary_check_ff;
      backup_reading_in   = backup_reading_ff;
      backup_version_in   = backup_version_ff;
      backup_check_in     = backup_check_ff;
      moved_since_save_in = moved_since_save_ff;
      save_pending_in     = save_pending_ff;
      res0                = '0;
      res1                = '0;
      res0.final_result   = 1'b1;
      res1.final_result   = 1'b1;
      res_count           = 2'd1;

      if (op_ff == OP_INIT) begin
         if (primary_ok && backup_ok) begin
            // keep the newer copy, primary wins ties, nothing written
            if (sp_version_ff >= sb_version_ff) begin
               primary_reading_in = sp_reading_ff;
               primary_version_in = sp_version_ff;
               primary_check_in   = sp_check_ff;
            end else begin
               primary_reading_in = sb_reading_ff;
               primary_version_in = sb_version_ff;
               primary_check_in   = sb_check_ff;
            end
            backup_reading_in      = primary_reading_in;
            backup_version_in      = primary_version_in;
            backup_check_in        = primary_check_in;
            res0.recovery_status   = STATUS_BOTH_VALID;
         end else if (primary_ok) begin
            primary_reading_in     = sp_reading_ff;
            primary_version_in     = sp_version_ff;
            primary_check_in       = sp_check_ff;
            backup_reading_in      = sp_reading_ff;
            backup_version_in      = sp_version_ff;
            backup_check_in        = sp_check_ff;
            res0.write_enable      = 1'b1;
            res0.write_target      = TARGET_BACKUP;
            res0.write_reading     = sp_reading_ff;
            res0.write_version     = sp_version_ff;
            res0.write_check       = sp_check_ff;
            res0.recovery_status   = STATUS_BACKUP_REBUILT;
         end else if (backup_ok) begin
            primary_reading_in     = sb_reading_ff;
            primary_version_in     = sb_version_ff;
            primary_check_in       = sb_check_ff;
            backup_reading_in      = sb_reading_ff;
            backup_version_in      = sb_version_ff;
            backup_check_in        = sb_check_ff;
            res0.write_enable      = 1'b1;
            res0.write_target      = TARGET_PRIMARY;
            res0.write_reading     = sb_reading_ff;
            res0.write_version     = sb_version_ff;
            res0.write_check       = sb_check_ff;
            res0.recovery_status   = STATUS_PRIMARY_REBUILT;
         end else begin
            // both bad: all-zero records, crc of zeros is zero
            primary_reading_in     = '0;
            primary_version_in     = '0;
            primary_check_in       = record_crc('0, '0);
            backup_reading_in      = '0;
            backup_version_in      = '0;
            backup_check_in        = primary_check_in;
            res0.write_enable      = 1'b1;
            res0.write_target      = TARGET_PRIMARY;
            res0.write_check       = primary_check_in;
            res0.recovery_status   = STATUS_BOTH_RESET;
            res0.final_result      = 1'b0;
            res1.write_enable      = 1'b1;
            res1.write_target      = TARGET_BACKUP;
            res1.write_check       = primary_check_in;
            res1.recovery_status   = STATUS_BOTH_RESET;
            res_count              = 2'd2;
         end
      end else begin
         // new distance: old primary rolls into backup, version bumps
         if (feet != primary_reading_ff) begin
            backup_reading_in  = primary_reading_ff;
            backup_version_in  = primary_version_ff;
            backup_check_in    = primary_check_ff;
            primary_reading_in = feet;
            primary_version_in = bumped_version;
            primary_check_in   = record_crc(feet, bumped_version);
            save_pending_in    = 1'b1;
         end
         if (!moving_ff && moved_since_save_ff && save_pending_in) begin
            // first stop after motion: backup write, then primary write
            moved_since_save_in = 1'b0;
            save_pending_in     = 1'b0;
            res0.write_enable   = 1'b1;
            res0.write_target   = TARGET_BACKUP;
            res0.write_reading  = backup_reading_in;
            res0.write_version  = backup_version_in;
            res0.write_check    = backup_check_in;
            res0.final_result   = 1'b0;
            res1.write_enable   = 1'b1;
            res1.write_target   = TARGET_PRIMARY;
            res1.write_reading  = primary_reading_in;
            res1.write_version  = primary_version_in;
            res1.write_check    = primary_check_in;
            res_count           = 2'd2;
         end else if (moving_ff) begin
            moved_since_save_in = 1'b1;
         end
      end

      res0.odometer_feet = primary_reading_in;
      res1.odometer_feet = primary_reading_in;
   end

   // result buffer next state
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (advance) begin
         head_in  = res0;
         tail_in  = res1;
         count_in = res_count;
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end
   end

   // control and record state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         count_ff            <= 2'd0;
         primary_reading_ff  <= '0;
         primary_version_ff  <= '0;
         primary_check_ff    <= '0;
         backup_reading_ff   <= '0;
         backup_version_ff   <= '0;
         backup_check_ff     <= '0;
         moved_since_save_ff <= 1'b0;
         save_pending_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (advance) begin
            primary_reading_ff  <= primary_reading_in;
            primary_version_ff  <= primary_version_in;
            primary_check_ff    <= primary_check_in;
            backup_reading_ff   <= backup_reading_in;
            backup_version_ff   <= backup_version_in;
            backup_check_ff     <= backup_check_in;
            moved_since_save_ff <= moved_since_save_in;
            save_pending_ff     <= save_pending_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_tuser[0];
         sp_reading_ff <= req_tdata[31:0];
         sp_version_ff <= req_tdata[63:32];
         sp_check_ff   <= req_tdata[71:64];
         sb_reading_ff <= req_tdata[103:72];
         sb_version_ff <= req_tdata[135:104];
         sb_check_ff   <= req_tdata[143:136];
         moving_ff     <= req_tdata[144];
         miles_ff      <= req_tdata[176:145];
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // response port
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {6'd0, head_ff.odometer_feet, head_ff.recovery_status,
                        head_ff.write_check, head_ff.write_version, head_ff.write_reading};
   assign rsp_tuser  = {head_ff.write_target, head_ff.write_enable};
   assign rsp_tlast  = head_ff.final_result;

endmodule

### verif/odometer_tb_pkg.sv
package odometer_tb_pkg;

   import dros_pkg::*;

   // one request word, unpacked
   typedef struct {
      bit        op;
      bit [31:0] pri_reading;
      bit [31:0] pri_version;
      bit [7:0]  pri_check;
      bit [31:0] bak_reading;
      bit [31:0] bak_version;
      bit [7:0]  bak_check;
      bit        moving;
      bit [31:0] miles;
   } odo_request_type;

   // crc-8 as a bitwise lfsr: bytes in order, msb of each byte first
   function automatic bit [7:0] odo_crc8(input bit [31:0] feet, input bit [31:0] ver);
      bit [63:0] msg;
      bit [7:0]  crc;
      bit        fb;
      int        idx;
      msg = {ver, feet};
      crc = 8'h00;
      for (int b = 0; b < 64; b++) begin
         idx = (b / 8) * 8 + 7 - (b % 8);
         fb  = crc[7] ^ msg[idx];
         crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   // q16.16 miles to feet, rounded half up
   function automatic bit [31:0] miles_to_feet(input bit [31:0] miles);
      bit [47:0] scaled;
      scaled = 48'(miles) * 48'd5280 + 48'h8000;
      return scaled[47:16];
   endfunction

   class odometer_scoreboard;
      bit [31:0]  pri_feet;
      bit [31:0]  pri_ver;
      bit [7:0]   pri_crc;
      bit [31:0]  bak_feet;
      bit [31:0]  bak_ver;
      bit [7:0]   bak_crc;
      bit         moved_since_save;
      bit         save_pending;
      result_type expected_q[$];
      int         errors;

      function int pending();
         return expected_q.size();
      endfunction

      function void roll_primary_to_backup();
         bak_feet = pri_feet;
         bak_ver  = pri_ver;
         bak_crc  = pri_crc;
      endfunction

      function void restore_primary_from_backup();
         pri_feet = bak_feet;
         pri_ver  = bak_ver;
         pri_crc  = bak_crc;
      endfunction

      // odometer field always shows the primary after the word
      function void push_result(input bit we, input bit target, input bit [31:0] feet,
                                input bit [31:0] ver, input bit [7:0] crc,
                                input bit [1:0] status, input bit last);
         result_type r;
         r.write_enable    = we;
         r.write_target    = we ? target : 1'b0;
         r.write_reading   = we ? feet : 32'h0;
         r.write_version   = we ? ver : 32'h0;
         r.write_check     = we ? crc : 8'h00;
         r.recovery_status = status;
         r.odometer_feet   = pri_feet;
         r.final_result    = last;
         expected_q.push_back(r);
      endfunction

      function void note_request(input odo_request_type item);
         bit        pri_ok;
         bit        bak_ok;
         bit [31:0] feet;
         if (item.op == OP_INIT) begin
            pri_feet = item.pri_reading;
            pri_ver  = item.pri_version;
            pri_crc  = item.pri_check;
            bak_feet = item.bak_reading;
            bak_ver  = item.bak_version;
            bak_crc  = item.bak_check;
            pri_ok   = odo_crc8(pri_feet, pri_ver) == pri_crc;
            bak_ok   = odo_crc8(bak_feet, bak_ver) == bak_crc;
            if (pri_ok && bak_ok) begin
               // newer version wins, primary on a tie
               if (pri_ver >= bak_ver) roll_primary_to_backup();
               else restore_primary_from_backup();
               push_result(1'b0, 1'b0, 32'h0, 32'h0, 8'h00, STATUS_BOTH_VALID, 1'b1);
            end else if (pri_ok) begin
               roll_primary_to_backup();
               push_result(1'b1, TARGET_BACKUP, bak_feet, bak_ver, bak_crc,
                           STATUS_BACKUP_REBUILT, 1'b1);
            end else if (bak_ok) begin
               restore_primary_from_backup();
               push_result(1'b1, TARGET_PRIMARY, pri_feet, pri_ver, pri_crc,
                           STATUS_PRIMARY_REBUILT, 1'b1);
            end else begin
               pri_feet = 32'h0;
               pri_ver  = 32'h0;
               pri_crc  = odo_crc8(32'h0, 32'h0);
               roll_primary_to_backup();
               push_result(1'b1, TARGET_PRIMARY, pri_feet, pri_ver, pri_crc,
                           STATUS_BOTH_RESET, 1'b0);
               push_result(1'b1, TARGET_BACKUP, bak_feet, bak_ver, bak_crc,
                           STATUS_BOTH_RESET, 1'b1);
            end
         end else begin
            feet = miles_to_feet(item.miles);
            if (feet != pri_feet) begin
               roll_primary_to_backup();
               pri_feet     = feet;
               pri_ver      = pri_ver + 32'd1;
               pri_crc      = odo_crc8(pri_feet, pri_ver);
               save_pending = 1'b1;
            end
            if (!item.moving && moved_since_save && save_pending) begin
               moved_since_save = 1'b0;
               save_pending     = 1'b0;
               push_result(1'b1, TARGET_BACKUP, bak_feet, bak_ver, bak_crc,
                           STATUS_BOTH_VALID, 1'b0);
               push_result(1'b1, TARGET_PRIMARY, pri_feet, pri_ver, pri_crc,
                           STATUS_BOTH_VALID, 1'b1);
            end else begin
               if (item.moving) moved_since_save = 1'b1;
               push_result(1'b0, 1'b0, 32'h0, 32'h0, 8'h00, STATUS_BOTH_VALID, 1'b1);
            end
         end
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got, input realtime at_ns);
         if (got !== want) begin
            $display("%0.1f ns: %s mismatch, expected %h, actual %h", at_ns, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(input result_type got, input realtime at_ns);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0.1f ns: result word with nothing expected, expected none, actual %h",
                     at_ns, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("write_enable", 32'(want.write_enable), 32'(got.write_enable), at_ns);
         compare_field("write_target", 32'(want.write_target), 32'(got.write_target), at_ns);
         compare_field("write_reading", want.write_reading, got.write_reading, at_ns);
         compare_field("write_version", want.write_version, got.write_version, at_ns);
         compare_field("write_check", 32'(want.write_check), 32'(got.write_check), at_ns);
         compare_field("recovery_status", 32'(want.recovery_status),
                       32'(got.recovery_status), at_ns);
         compare_field("odometer_feet", want.odometer_feet, got.odometer_feet, at_ns);
         compare_field("final_result", 32'(want.final_result), 32'(got.final_result), at_ns);
      endfunction
   endclass

endpackage

### verif/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import dros_pkg::*;
   import odometer_tb_pkg::*;

   localparam int ITEM_COUNT  = 1400;
   localparam int HOLD_AT     = 600;   // accepted words before the long receiver hold
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_AT    = 1000;  // random word index where the sender waits for drain
   localparam int TAIL_CYCLES = 20;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   // tdata from bit 0: stored_primary_reading, stored_primary_version,
   // stored_primary_check, stored_backup_reading, stored_backup_version,
   // stored_backup_check, moving, distance_miles, zero pad
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // tuser from bit 0: operation
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata from bit 0: write_reading, write_version, write_check,
   // recovery_status, odometer_feet, zero pad
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   // tuser from bit 0: write_enable, write_target
   wire  [RSP_USER_W-1:0] rsp_tuser;
   wire                   rsp_tlast;

   odometer_scoreboard sb = new();
   int accepted_words = 0;
   int burst_left     = 0;   // sender words left in a no-gap stretch

   always #5 clock = ~clock;

   dual_record_odometer_store uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // request fields packed from bit 0, zero filled to whole bytes
   function automatic logic [REQ_DATA_W-1:0] pack_request(input odo_request_type item);
      return REQ_DATA_W'({item.miles, item.moving, item.bak_check, item.bak_version,
                          item.bak_reading, item.pri_check, item.pri_version,
                          item.pri_reading});
   endfunction

   // init word; a bad record gets a check that is off by a nonzero pattern
   function automatic odo_request_type make_init(input bit [31:0] pr, input bit [31:0] pv,
                                                 input bit p_ok, input bit [31:0] br,
                                                 input bit [31:0] bv, input bit b_ok);
      odo_request_type item;
      item.op          = OP_INIT;
      item.pri_reading = pr;
      item.pri_version = pv;
      item.pri_check   = odo_crc8(pr, pv) ^ (p_ok ? 8'h00 : 8'($urandom_range(1, 255)));
      item.bak_reading = br;
      item.bak_version = bv;
      item.bak_check   = odo_crc8(br, bv) ^ (b_ok ? 8'h00 : 8'($urandom_range(1, 255)));
      // update-only fields carry noise
      item.moving      = 1'($urandom_range(0, 1));
      item.miles       = $urandom;
      return item;
   endfunction

   function automatic odo_request_type make_update(input bit mv, input bit [31:0] miles);
      odo_request_type item;
      item.op          = OP_UPDATE;
      // init-only fields carry noise
      item.pri_reading = $urandom;
      item.pri_version = $urandom;
      item.pri_check   = 8'($urandom);
      item.bak_reading = $urandom;
      item.bak_version = $urandom;
      item.bak_check   = 8'($urandom);
      item.moving      = mv;
      item.miles       = miles;
      return item;
   endfunction

   // mostly no gap, some short gaps, a few long ones, and stretches with none
   function automatic int sender_gap();
      int r;
      // keep the input busy around the long receiver hold
      if (accepted_words >= HOLD_AT - 10 && accepted_words < HOLD_AT + 60) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a rising edge, returns at the edge where the word is taken
   task automatic send_item(input odo_request_type item);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_request(item);
      req_tuser  <= item.op;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(item);
      accepted_words++;
   endtask

   // sender idles until every expected result word is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // response checker, sampling at the edge before any update lands
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.write_enable    = rsp_tuser[0];
         got.write_target    = rsp_tuser[1];
         got.write_reading   = rsp_tdata[31:0];
         got.write_version   = rsp_tdata[63:32];
         got.write_check     = rsp_tdata[71:64];
         got.recovery_status = rsp_tdata[73:72];
         got.odometer_feet   = rsp_tdata[105:74];
         got.final_result    = rsp_tlast;
         sb.check_result(got, $realtime);
      end
   end

   // receiver: random stalls, free-running stretches and one long hold
   initial begin
      int stall_left;
      int free_left;
      int r;
      bit long_hold_done;
      stall_left     = 0;
      free_left      = 0;
      long_hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!long_hold_done && accepted_words >= HOLD_AT) begin
            // block backs up and must stall its input
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (free_left > 0) begin
            rsp_tready <= 1'b1;
            free_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 5) free_left = $urandom_range(20, 80);
            else if (r < 22) stall_left = $urandom_range(1, 3);
            else if (r < 25) stall_left = $urandom_range(8, 40);
         end
      end
   end

   // stimulus
   initial begin
      odo_request_type item;
      bit [31:0]       trip_miles;
      bit [31:0]       pv;
      bit [31:0]       bv;
      int              moving_left;
      int              stop_left;
      int              r;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: rounding, saves, version wrap and every recovery path
      send_item(make_update(1'b0, 32'h0));            // stopped at zero, nothing to do
      send_item(make_update(1'b1, 32'h0001_0000));    // one mile while moving
      send_item(make_update(1'b0, 32'h0001_0000));    // first stop, both records written
      send_item(make_update(1'b0, 32'h0001_0000));    // second stop, nothing left to save
      send_item(make_update(1'b1, 32'hFFFF_FFFF));    // largest distance
      send_item(make_update(1'b1, 32'd6));            // rounds down to zero feet
      send_item(make_update(1'b1, 32'd7));            // rounds up to one foot
      send_item(make_update(1'b1, 32'd1024));         // exactly half a foot over
      send_item(make_update(1'b0, 32'd1024));         // save
      send_item(make_update(1'b1, 32'd1024));         // moving, no change
      send_item(make_update(1'b0, 32'd1024));         // stop with nothing pending
      send_item(make_init(32'd100, 32'd7, 1'b1, 32'd200, 32'd7, 1'b1));   // tie
      send_item(make_init(32'd300, 32'd5, 1'b1, 32'd400, 32'd9, 1'b1));   // backup newer
      send_item(make_init(32'd500, 32'hFFFF_FFFF, 1'b1, 32'd600, 32'd0, 1'b1));
      send_item(make_init(32'd12345, 32'd3, 1'b1, 32'd999, 32'd4, 1'b0)); // primary only
      send_item(make_init(32'd1, 32'd2, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1));
      send_item(make_init(32'd7, 32'd7, 1'b0, 32'd8, 32'd8, 1'b0));       // both bad
      send_item(make_init(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0, 1'b0));
      send_item(make_update(1'b1, 32'h0));            // change bumps version past max
      send_item(make_update(1'b0, 32'h0));            // save the wrapped version
      item = make_init(32'h0, 32'h0, 1'b1, 32'h0, 32'h0, 1'b1);
      item.pri_check = 8'hFF;                         // all-ones check, primary bad
      item.bak_check = 8'h00;
      send_item(item);
      send_item(make_update(1'b0, 32'h0002_0000));    // change while stopped
      send_item(make_update(1'b1, 32'h0002_0000));
      send_item(make_update(1'b0, 32'h0002_0000));    // save of the pending change
      wait_drained();

      // random: mostly trips of motion and stops, some init words and noise
      trip_miles  = $urandom;
      moving_left = 0;
      stop_left   = 0;
      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (i == DRAIN_AT) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 8) begin
            pv = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2)
                                              : $urandom;
            case ($urandom_range(0, 2))
               0: bv = pv;
               1: bv = pv + $urandom_range(0, 3) - 1;
               default: bv = $urandom;
            endcase
            item = make_init(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 99999),
                             pv, $urandom_range(0, 2) != 0,
                             ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 99999),
                             bv, $urandom_range(0, 2) != 0);
         end else if (r < 14) begin
            item = make_update(1'($urandom_range(0, 1)), $urandom);
         end else if (moving_left > 0) begin
            // small steps keep some words at the same rounded feet
            trip_miles += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000)
                                                      : $urandom_range(0, 40);
            item = make_update(1'b1, trip_miles);
            moving_left--;
            if (moving_left == 0) stop_left = $urandom_range(1, 3);
         end else begin
            if ($urandom_range(0, 3) == 0) trip_miles += $urandom_range(0, 20);
            item = make_update(1'b0, trip_miles);
            if (stop_left > 0) stop_left--;
            if (stop_left == 0) moving_left = $urandom_range(1, 12);
         end
         send_item(item);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
